[sv/lobm_pkg.sv]
package lobm_pkg;

  localparam int ORDER_SLOTS = 32;
  localparam int PRICE_BITS  = 16;
  localparam int QTY_BITS    = 16;
  localparam int ID_BITS     = 16;
  localparam int ARR_BITS    = 32;
  localparam int IDX_W       = $clog2(ORDER_SLOTS);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_BAD    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RK_TRADE     = 3'd0,
    RK_RESTED    = 3'd1,
    RK_FILLED    = 3'd2,
    RK_CANCELLED = 3'd3,
    RK_MODIFIED  = 3'd4,
    RK_NOT_FOUND = 3'd5,
    RK_BOOK_FULL = 3'd6
  } rkind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_BEST,
    S_DECIDE,
    S_FILL,
    S_SCAN_ID,
    S_ID_UPD,
    S_STATUS
  } eng_state_e;

  typedef struct packed {
    logic [1:0]            kind;
    logic [ID_BITS-1:0]    order_id;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   quantity;
    logic                  price_given;
    logic                  quantity_given;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            result_kind;
    logic [PRICE_BITS-1:0] trade_price;
    logic [QTY_BITS-1:0]   trade_quantity;
    logic [ID_BITS-1:0]    buy_order_id;
    logic [ID_BITS-1:0]    sell_order_id;
    logic [QTY_BITS-1:0]   remaining_quantity;
    logic                  last;
  } out_item_t;

  // classified command handed from front to engine
  typedef struct packed {
    kind_e    op;
    in_item_t item;
  } cmd_t;

endpackage

[sv/lobm_front.sv]
module lobm_front import lobm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_pop_i,
  output cmd_t     cmd_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.item = item_i;
    unique case (item_i.kind)
      KIND_ADD:    cmd_in.op = KIND_ADD;
      KIND_CANCEL: cmd_in.op = KIND_CANCEL;
      KIND_MODIFY: cmd_in.op = KIND_MODIFY;
      default:     cmd_in.op = KIND_BAD;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[sv/lobm_outq.sv]
module lobm_outq import lobm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_push_i,
  input  out_item_t res_i,
  output logic      res_full_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t result_o
);

  out_item_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign result_o   = mem_q[rptr_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[sv/lobm_engine.sv]
module lobm_engine import lobm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  cmd_t      cmd_i,
  output logic      res_push_o,
  output out_item_t res_o,
  input  logic      res_full_i
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER_SLOTS - 1);

  // slot store
  logic                  valid_q [ORDER_SLOTS];
  logic                  side_q  [ORDER_SLOTS];
  logic [PRICE_BITS-1:0] price_q [ORDER_SLOTS];
  logic [QTY_BITS-1:0]   qty_q   [ORDER_SLOTS];
  logic [ID_BITS-1:0]    id_q    [ORDER_SLOTS];
  logic [ARR_BITS-1:0]   arr_q   [ORDER_SLOTS];

  eng_state_e            state_q, state_d;
  kind_e                 op_q, op_d;
  in_item_t              item_q, item_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [QTY_BITS-1:0]   rem_q, rem_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [PRICE_BITS-1:0] best_price_q, best_price_d;
  logic [ARR_BITS-1:0]   best_arr_q, best_arr_d;
  logic [QTY_BITS-1:0]   best_qty_q, best_qty_d;
  logic [ID_BITS-1:0]    best_id_q, best_id_d;
  logic                  free_found_q, free_found_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic [ARR_BITS-1:0]   counter_q, counter_d;
  rkind_e                st_kind_q, st_kind_d;
  logic [QTY_BITS-1:0]   st_rem_q, st_rem_d;

  // current scanned slot
  logic                  c_valid, c_side;
  logic [PRICE_BITS-1:0] c_price;
  logic [QTY_BITS-1:0]   c_qty;
  logic [ID_BITS-1:0]    c_id;
  logic [ARR_BITS-1:0]   c_arr;
  logic                  crosses, cand, better;
  logic [QTY_BITS-1:0]   fill, new_qty;

  // single write port
  logic                  wr_valid_en, wr_valid_val;
  logic                  wr_new_en, wr_price_en, wr_qty_en, wr_arr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [PRICE_BITS-1:0] wr_price;
  logic [QTY_BITS-1:0]   wr_qty;

  assign c_valid = valid_q[idx_q];
  assign c_side  = side_q[idx_q];
  assign c_price = price_q[idx_q];
  assign c_qty   = qty_q[idx_q];
  assign c_id    = id_q[idx_q];
  assign c_arr   = arr_q[idx_q];

  always_comb begin
    crosses = item_q.side ? (c_price >= item_q.price) : (c_price <= item_q.price);
    cand    = c_valid && (c_side != item_q.side) && crosses;
    if (!found_q) begin
      better = 1'b1;
    end else if (c_price != best_price_q) begin
      better = item_q.side ? (c_price > best_price_q) : (c_price < best_price_q);
    end else begin
      // ties go to the earlier arrival, the lower arrival stamp
      better = c_arr < best_arr_q;
    end
    fill    = (rem_q < best_qty_q) ? rem_q : best_qty_q;
    new_qty = item_q.quantity_given ? item_q.quantity : best_qty_q;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    item_d       = item_q;
    idx_d        = idx_q;
    rem_d        = rem_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_price_d = best_price_q;
    best_arr_d   = best_arr_q;
    best_qty_d   = best_qty_q;
    best_id_d    = best_id_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    counter_d    = counter_q;
    st_kind_d    = st_kind_q;
    st_rem_d     = st_rem_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    res_o        = '0;
    wr_valid_en  = 1'b0;
    wr_valid_val = 1'b0;
    wr_new_en    = 1'b0;
    wr_price_en  = 1'b0;
    wr_qty_en    = 1'b0;
    wr_arr_en    = 1'b0;
    wr_idx       = best_idx_q;
    wr_price     = item_q.price;
    wr_qty       = new_qty;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o    = 1'b1;
          op_d         = cmd_i.op;
          item_d       = cmd_i.item;
          rem_d        = cmd_i.item.quantity;
          idx_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          unique case (cmd_i.op) inside
            KIND_ADD: begin
              if (cmd_i.item.quantity == '0) begin
                st_kind_d = RK_FILLED;
                st_rem_d  = '0;
                state_d   = S_STATUS;
              end else begin
                state_d = S_SCAN_BEST;
              end
            end
            KIND_CANCEL, KIND_MODIFY: state_d = S_SCAN_ID;
            default: begin
              st_kind_d = RK_NOT_FOUND;
              st_rem_d  = '0;
              state_d   = S_STATUS;
            end
          endcase
        end
      end

      S_SCAN_BEST: begin
        if (cand && better) begin
          found_d      = 1'b1;
          best_idx_d   = idx_q;
          best_price_d = c_price;
          best_arr_d   = c_arr;
          best_qty_d   = c_qty;
          best_id_d    = c_id;
        end
        if (!c_valid && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (found_q) begin
          state_d = S_FILL;
        end else if (free_found_q) begin
          wr_idx       = free_idx_q;
          wr_valid_en  = 1'b1;
          wr_valid_val = 1'b1;
          wr_new_en    = 1'b1;
          wr_price_en  = 1'b1;
          wr_qty_en    = 1'b1;
          wr_qty       = rem_q;
          wr_arr_en    = 1'b1;
          counter_d    = counter_q + 1'b1;
          st_kind_d    = RK_RESTED;
          st_rem_d     = rem_q;
          state_d      = S_STATUS;
        end else begin
          st_kind_d = RK_BOOK_FULL;
          st_rem_d  = rem_q;
          state_d   = S_STATUS;
        end
      end

      S_FILL: begin
        if (!res_full_i) begin
          res_push_o           = 1'b1;
          res_o.result_kind    = RK_TRADE;
          res_o.trade_price    = best_price_q;
          res_o.trade_quantity = fill;
          res_o.buy_order_id   = item_q.side ? best_id_q : item_q.order_id;
          res_o.sell_order_id  = item_q.side ? item_q.order_id : best_id_q;
          wr_qty_en            = 1'b1;
          wr_qty               = best_qty_q - fill;
          if (fill == best_qty_q) begin
            wr_valid_en  = 1'b1;
            wr_valid_val = 1'b0;
          end
          rem_d        = rem_q - fill;
          idx_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          if (rem_q == fill) begin
            st_kind_d = RK_FILLED;
            st_rem_d  = '0;
            state_d   = S_STATUS;
          end else begin
            state_d = S_SCAN_BEST;
          end
        end
      end

      S_SCAN_ID: begin
        idx_d = idx_q + 1'b1;
        if (c_valid && (c_id == item_q.order_id)) begin
          best_idx_d = idx_q;
          best_qty_d = c_qty;
          state_d    = S_ID_UPD;
        end else if (idx_q == LAST_IDX) begin
          st_kind_d = RK_NOT_FOUND;
          st_rem_d  = '0;
          state_d   = S_STATUS;
        end
      end

      S_ID_UPD: begin
        state_d = S_STATUS;
        if (op_q == KIND_CANCEL) begin
          wr_valid_en  = 1'b1;
          wr_valid_val = 1'b0;
          st_kind_d    = RK_CANCELLED;
          st_rem_d     = '0;
        end else begin
          wr_price_en = item_q.price_given;
          wr_qty_en   = 1'b1;
          st_kind_d   = RK_MODIFIED;
          if (new_qty == '0) begin
            wr_valid_en  = 1'b1;
            wr_valid_val = 1'b0;
            st_rem_d     = '0;
          end else begin
            wr_arr_en = 1'b1;
            counter_d = counter_q + 1'b1;
            st_rem_d  = new_qty;
          end
        end
      end

      S_STATUS: begin
        if (!res_full_i) begin
          res_push_o               = 1'b1;
          res_o.result_kind        = st_kind_q;
          res_o.remaining_quantity = st_rem_q;
          res_o.last               = 1'b1;
          state_d                  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_new_en) begin
      side_q[wr_idx] <= item_q.side;
      id_q[wr_idx]   <= item_q.order_id;
    end
    if (wr_price_en) price_q[wr_idx] <= wr_price;
    if (wr_qty_en)   qty_q[wr_idx]   <= wr_qty;
    if (wr_arr_en)   arr_q[wr_idx]   <= counter_q;
    op_q         <= op_d;
    item_q       <= item_d;
    idx_q        <= idx_d;
    rem_q        <= rem_d;
    best_idx_q   <= best_idx_d;
    best_price_q <= best_price_d;
    best_arr_q   <= best_arr_d;
    best_qty_q   <= best_qty_d;
    best_id_q    <= best_id_d;
    free_idx_q   <= free_idx_d;
    st_kind_q    <= st_kind_d;
    st_rem_q     <= st_rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      counter_q    <= '0;
      for (int i = 0; i < ORDER_SLOTS; i++) valid_q[i] <= 1'b0;
    end else begin
      state_q      <= state_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      counter_q    <= counter_d;
      if (wr_valid_en) valid_q[wr_idx] <= wr_valid_val;
    end
  end

  a_trade_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.result_kind == RK_TRADE |-> res_o.trade_quantity != '0)
    else $error("trade item with zero quantity");

  a_last_only_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (res_o.last == (res_o.result_kind != RK_TRADE)))
    else $error("last flag does not match result kind");

  a_idle_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !res_push_o)
    else $error("result pushed while idle");

  a_fill_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> found_q)
    else $error("fill without a best order");

endmodule

[sv/limit_order_book_matcher.sv]
// Price-time priority order book: add, cancel and modify items go in through a
// two-entry command queue, trade and status items come out through a two-entry
// result queue, and every input item ends with one status item that has last
// set. The engine scans the slot registers one slot per clock. An add scans
// the whole book for the best crossing order before each fill, a cancel or
// modify scans for its order id, and the engine takes the next command only
// once the status item of the current one has been pushed. A zero-quantity
// add or an unknown kind gets its status item without a scan.
module limit_order_book_matcher import lobm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  in_item_t  item_i,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t result_o
);

  logic      cmd_valid, cmd_pop, res_push, res_full;
  cmd_t      cmd;
  out_item_t res;

  lobm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  lobm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  lobm_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .result_o   (result_o)
  );

endmodule
